### design/msv_pkg.sv
// Shared types and constants for the multipass sector vote block.
package msv_pkg;

    localparam int HASH_W  = 32;
    localparam int C2_W    = 12;
    localparam int CNT_W   = 5;
    localparam int PASS_W  = 4;
    localparam int VERD_W  = 2;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] PASS_CAP       = 5'd16;
    localparam logic [CNT_W-1:0] FAIL_LIMIT     = 5'd3;
    localparam logic [CNT_W-1:0] UNUSABLE_LIMIT = 5'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PASSES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MATCHES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PASSES       = 2'd2;

    localparam logic [VERD_W-1:0] VERDICT_CONTINUE = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_MATCH    = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_FALLBACK = 2'd2;
    localparam logic [VERD_W-1:0] VERDICT_FAILED   = 2'd3;

    typedef struct packed {
        logic              read_ok;
        logic [C2_W-1:0]   c2_error_count;
        logic [HASH_W-1:0] sector_hash;
    } t_pass_in;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic [HASH_W-1:0] final_hash;
        logic [CNT_W-1:0]  matching_passes;
        logic [CNT_W-1:0]  passes_required;
        logic [CNT_W-1:0]  total_passes;
        logic [CNT_W-1:0]  c2_error_passes;
        logic              is_secure;
        logic [PASS_W-1:0] source_pass;
    } t_vote_out;

    typedef struct packed {
        logic [HASH_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic [PASS_W-1:0] first_pass;
    } t_entry;

endpackage

### design/multipass_sector_vote_top.sv
// Top level of the multipass sector vote block: hash table, sequencer and verdict logic.

// One request per read pass. A request is taken when start is high and busy is low;
// busy then stays high until the result appears on o_out with o_done high for one
// cycle, and that cycle must be captured. The taken request is followed by a search
// of the hash table: one table read per cycle through its single read port, then a
// last compare and a closing step. Next comes a rescan of the table, new hash
// included, for the acceptance and fallback picks. The verdict is formed last. A
// hash that is found early shortens the search, and an empty table ends it with no
// table read. A new hash that finds the table full is dropped. An unusable pass
// that ends the sector skips the search, and an unusable pass that does not end the
// sector skips both table walks.
module multipass_sector_vote_top
    import msv_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_pass_in             i_in,
    output logic                 busy,
    output logic                 o_done,
    output t_vote_out            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]        r_state;
    logic [CFG_W-1:0]  r_max_passes, r_required, r_min_passes;

    logic [UW-1:0]     r_used;
    logic [CNT_W-1:0]  r_pass, r_c2_total;
    logic [1:0]        r_fail;
    logic [2:0]        r_unusable;

    logic [HASH_W-1:0] r_hash;
    logic [PASS_W-1:0] r_first;
    logic [CNT_W-1:0]  r_total;
    logic              r_usable, r_end, r_min_ok;

    logic [UW-1:0]     r_addr;
    logic              r_rvalid;
    logic [AW-1:0]     r_ridx;
    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_q;

    logic              r_have;
    t_entry            r_pick, r_best;

    logic              r_done;
    t_vote_out         r_out;

    // Per-pass bookkeeping, evaluated on the request inputs.
    logic [CNT_W-1:0]  n_limit, n_total, n_c2_total;
    logic [1:0]        n_fail;
    logic [2:0]        n_unusable;
    logic              n_c2_nz, n_polluted, n_usable, n_end, n_streak_end;

    always_comb begin
        if (r_max_passes == '0) begin
            n_limit = 5'd1;
        end else if (r_max_passes > PASS_CAP) begin
            n_limit = PASS_CAP;
        end else begin
            n_limit = r_max_passes;
        end
        n_total    = (r_pass >= PASS_CAP) ? PASS_CAP : r_pass + 5'd1;
        n_c2_nz    = (i_in.c2_error_count != '0);
        n_c2_total = (n_c2_nz && r_c2_total < PASS_CAP) ? r_c2_total + 5'd1 : r_c2_total;
        n_polluted = i_in.read_ok && n_c2_nz && (r_pass < (n_limit >> 1));
        n_usable   = i_in.read_ok && !n_polluted;
        n_fail       = 2'd0;
        n_unusable   = 3'd0;
        n_streak_end = 1'b0;
        if (!i_in.read_ok) begin
            n_fail       = (5'(r_fail) < FAIL_LIMIT) ? r_fail + 2'd1 : r_fail;
            n_unusable   = (5'(r_unusable) < UNUSABLE_LIMIT) ? r_unusable + 3'd1 : r_unusable;
            n_streak_end = (5'(n_fail) >= FAIL_LIMIT);
        end else if (n_polluted) begin
            n_unusable   = (5'(r_unusable) < UNUSABLE_LIMIT) ? r_unusable + 3'd1 : r_unusable;
            n_streak_end = (5'(n_unusable) >= UNUSABLE_LIMIT);
        end
        n_end = n_streak_end || (n_total >= n_limit);
    end

    // Table walk: one read issued per cycle, compared the cycle after.
    logic              issue, match, not_found, tab_we;
    logic [AW-1:0]     tab_waddr;
    t_entry            tab_wdata;

    always_comb begin
        issue     = (r_addr < r_used);
        match     = r_rvalid && (r_q.value == r_hash);
        not_found = !r_rvalid && !issue;
        tab_we    = (r_state == ST_SEARCH) && (match || (not_found && r_used < DEPTH_U));
        if (match) begin
            tab_waddr            = r_ridx;
            tab_wdata.value      = r_hash;
            tab_wdata.count      = (r_q.count < PASS_CAP) ? r_q.count + 5'd1 : r_q.count;
            tab_wdata.first_pass = r_q.first_pass;
        end else begin
            tab_waddr            = r_used[AW-1:0];
            tab_wdata.value      = r_hash;
            tab_wdata.count      = 5'd1;
            tab_wdata.first_pass = r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_mem[tab_waddr] <= tab_wdata;
        end
        r_q <= r_mem[r_addr[AW-1:0]];
    end

    // Verdict formed from the scan results.
    t_vote_out n_out;

    always_comb begin
        n_out                 = '0;
        n_out.total_passes    = r_total;
        n_out.c2_error_passes = r_c2_total;
        n_out.verdict         = VERDICT_CONTINUE;
        if (r_usable && r_min_ok && r_have) begin
            n_out.verdict         = VERDICT_MATCH;
            n_out.final_hash      = r_pick.value;
            n_out.matching_passes = r_pick.count;
            n_out.passes_required = r_total;
            n_out.is_secure       = (r_c2_total == '0);
            n_out.source_pass     = r_pick.first_pass;
        end else if (r_end) begin
            if (r_best.count != '0) begin
                n_out.verdict         = VERDICT_FALLBACK;
                n_out.final_hash      = r_best.value;
                n_out.matching_passes = r_best.count;
                n_out.passes_required = r_total;
                n_out.is_secure       = (r_best.count >= r_required) && (r_c2_total == '0);
                n_out.source_pass     = r_best.first_pass;
            end else begin
                n_out.verdict = VERDICT_FAILED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max_passes <= 5'd8;
            r_required   <= 5'd2;
            r_min_passes <= 5'd2;
            r_used       <= '0;
            r_pass       <= '0;
            r_c2_total   <= '0;
            r_fail       <= '0;
            r_unusable   <= '0;
            r_addr       <= '0;
            r_rvalid     <= 1'b0;
            r_have       <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_PASSES:       r_max_passes <= i_cfg_data;
                    CFG_REQUIRED_MATCHES: r_required   <= i_cfg_data;
                    CFG_MIN_PASSES:       r_min_passes <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_hash     <= i_in.sector_hash;
                        r_first    <= r_pass[PASS_W-1:0];
                        r_total    <= n_total;
                        r_pass     <= n_total;
                        r_c2_total <= n_c2_total;
                        r_fail     <= n_fail;
                        r_unusable <= n_unusable;
                        r_usable   <= n_usable;
                        r_end      <= n_end;
                        r_min_ok   <= (n_total >= r_min_passes);
                        r_addr     <= '0;
                        r_rvalid   <= 1'b0;
                        r_have     <= 1'b0;
                        r_best     <= '0;
                        if (n_usable) begin
                            r_state <= ST_SEARCH;
                        end else if (n_end) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (match || not_found) begin
                        if (not_found && r_used < DEPTH_U) begin
                            r_used <= r_used + UW'(1);
                        end
                        r_addr   <= '0;
                        r_rvalid <= 1'b0;
                        r_state  <= ST_SCAN;
                    end else begin
                        if (issue) begin
                            r_addr <= r_addr + UW'(1);
                        end
                        r_rvalid <= issue;
                        r_ridx   <= r_addr[AW-1:0];
                    end
                end
                ST_SCAN: begin
                    if (r_rvalid) begin
                        if (r_q.count >= r_required && (!r_have || r_q.value < r_pick.value)) begin
                            r_have <= 1'b1;
                            r_pick <= r_q;
                        end
                        // Highest count wins; equal counts go to the smaller hash.
                        if (r_q.count > r_best.count ||
                            (r_best.count != '0 && r_q.count == r_best.count &&
                             r_q.value < r_best.value)) begin
                            r_best <= r_q;
                        end
                    end
                    if (not_found) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        if (issue) begin
                            r_addr <= r_addr + UW'(1);
                        end
                        r_rvalid <= issue;
                    end
                end
                ST_DECIDE: begin
                    r_out   <= n_out;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                    if (n_out.verdict != VERDICT_CONTINUE) begin
                        r_used     <= '0;
                        r_pass     <= '0;
                        r_c2_total <= '0;
                        r_fail     <= '0;
                        r_unusable <= '0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

### tb/tb_multipass_sector_vote_top.sv
// Self-checking testbench for the multipass sector vote block with a verdict scoreboard.
module tb_multipass_sector_vote_top;
    import msv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 55;

    class verdict_board;
        logic [CFG_W-1:0]  max_passes_cfg;
        logic [CFG_W-1:0]  required_cfg;
        logic [CFG_W-1:0]  min_passes_cfg;
        logic [HASH_W-1:0] slot_hash [TABLE_DEPTH];
        logic [CNT_W-1:0]  slot_count [TABLE_DEPTH];
        logic [PASS_W-1:0] slot_first [TABLE_DEPTH];
        int unsigned       used;
        int unsigned       pass_no;
        int unsigned       fail_run;
        int unsigned       unusable_run;
        int unsigned       c2_passes;
        t_vote_out         pending_verdicts [$];
        int unsigned       mismatches;

        function new();
            max_passes_cfg = 5'd8;
            required_cfg   = 5'd2;
            min_passes_cfg = 5'd2;
            mismatches     = 0;
            clear_sector();
        endfunction

        function void clear_sector();
            foreach (slot_count[i]) begin
                slot_hash[i]  = '0;
                slot_count[i] = '0;
                slot_first[i] = '0;
            end
            used         = 0;
            pass_no      = 0;
            fail_run     = 0;
            unusable_run = 0;
            c2_passes    = 0;
        endfunction

        function void set_limits(logic [CFG_W-1:0] mp, logic [CFG_W-1:0] rm,
                                 logic [CFG_W-1:0] mn);
            max_passes_cfg = mp;
            required_cfg   = rm;
            min_passes_cfg = mn;
        endfunction

        function t_vote_out predict_verdict(t_pass_in p);
            t_vote_out   r;
            int unsigned limit, pass, total, pick, best, best_i;
            bit          ends, found, have;
            r      = '0;
            ends   = 1'b0;
            found  = 1'b0;
            have   = 1'b0;
            pick   = 0;
            best   = 0;
            best_i = 0;
            limit  = 32'(max_passes_cfg);
            if (limit < 1) limit = 1;
            if (limit > PASS_CAP) limit = 32'(PASS_CAP);
            pass    = pass_no;
            total   = (pass + 1 > PASS_CAP) ? 32'(PASS_CAP) : pass + 1;
            pass_no = total;

            if (p.c2_error_count != 0 && c2_passes < PASS_CAP) c2_passes++;

            if (!p.read_ok) begin
                if (fail_run < FAIL_LIMIT) fail_run++;
                if (unusable_run < UNUSABLE_LIMIT) unusable_run++;
                ends = (fail_run >= FAIL_LIMIT);
            end else begin
                fail_run = 0;
                // A C2-polluted read in the first half of the passes is not trusted.
                if (p.c2_error_count != 0 && pass < limit / 2) begin
                    if (unusable_run < UNUSABLE_LIMIT) unusable_run++;
                    ends = (unusable_run >= UNUSABLE_LIMIT);
                end else begin
                    unusable_run = 0;
                    for (int i = 0; i < used && !found; i++) begin
                        if (slot_hash[i] == p.sector_hash) begin
                            if (slot_count[i] < PASS_CAP) slot_count[i]++;
                            found = 1'b1;
                        end
                    end
                    // A new hash that finds the table full is dropped.
                    if (!found && used < TABLE_DEPTH) begin
                        slot_hash[used]  = p.sector_hash;
                        slot_count[used] = CNT_W'(1);
                        slot_first[used] = pass[PASS_W-1:0];
                        used++;
                    end
                    if (total >= min_passes_cfg) begin
                        for (int i = 0; i < used; i++) begin
                            if (slot_count[i] >= required_cfg &&
                                (!have || slot_hash[i] < slot_hash[pick])) begin
                                pick = i;
                                have = 1'b1;
                            end
                        end
                    end
                    if (have) begin
                        r.verdict         = VERDICT_MATCH;
                        r.final_hash      = slot_hash[pick];
                        r.matching_passes = slot_count[pick];
                        r.passes_required = CNT_W'(total);
                        r.total_passes    = CNT_W'(total);
                        r.c2_error_passes = CNT_W'(c2_passes);
                        r.is_secure       = (c2_passes == 0);
                        r.source_pass     = slot_first[pick];
                        clear_sector();
                        return r;
                    end
                end
            end

            if (total >= limit) ends = 1'b1;
            r.total_passes    = CNT_W'(total);
            r.c2_error_passes = CNT_W'(c2_passes);
            if (!ends) begin
                r.verdict = VERDICT_CONTINUE;
                return r;
            end

            // Most frequent hash wins; on equal counts the smaller hash wins.
            for (int i = 0; i < used; i++) begin
                if (slot_count[i] > best ||
                    (best > 0 && slot_count[i] == best && slot_hash[i] < slot_hash[best_i]))
                begin
                    best   = 32'(slot_count[i]);
                    best_i = i;
                end
            end
            if (best > 0) begin
                r.verdict         = VERDICT_FALLBACK;
                r.final_hash      = slot_hash[best_i];
                r.matching_passes = CNT_W'(best);
                r.passes_required = CNT_W'(total);
                r.is_secure       = (best >= required_cfg && c2_passes == 0);
                r.source_pass     = slot_first[best_i];
            end else begin
                r.verdict = VERDICT_FAILED;
            end
            clear_sector();
            return r;
        endfunction

        function void note_pass(t_pass_in p);
            pending_verdicts.push_back(predict_verdict(p));
        endfunction

        function void report(string what);
            if (mismatches < 10) $display("[%0t] %s", $realtime, what);
            mismatches++;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) report($sformatf("%s expected %0h got %0h", name, want, got));
        endfunction

        function void check_verdict(t_vote_out got);
            t_vote_out want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result with no request outstanding: verdict %0d hash %0h",
                                 got.verdict, got.final_hash));
                return;
            end
            want = pending_verdicts.pop_front();
            check_field("verdict", 32'(want.verdict), 32'(got.verdict));
            check_field("final_hash", want.final_hash, got.final_hash);
            check_field("matching_passes", 32'(want.matching_passes),
                        32'(got.matching_passes));
            check_field("passes_required", 32'(want.passes_required),
                        32'(got.passes_required));
            check_field("total_passes", 32'(want.total_passes), 32'(got.total_passes));
            check_field("c2_error_passes", 32'(want.c2_error_passes),
                        32'(got.c2_error_passes));
            check_field("is_secure", 32'(want.is_secure), 32'(got.is_secure));
            check_field("source_pass", 32'(want.source_pass), 32'(got.source_pass));
        endfunction

        function void check_drained();
            if (pending_verdicts.size() != 0)
                report($sformatf("%0d results never arrived", pending_verdicts.size()));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    t_pass_in             i_in;
    logic                 busy;
    logic                 o_done;
    t_vote_out            o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    verdict_board board = new();

    int preset_max [6] = '{16, 1, 31, 0, 16, 5};
    int preset_req [6] = '{16, 1, 3, 0, 2, 1};
    int preset_min [6] = '{0, 16, 31, 0, 2, 3};

    multipass_sector_vote_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_in      (i_in),
        .busy      (busy),
        .o_done    (o_done),
        .o_out     (o_out),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Results are checked before the request taken at the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) board.check_verdict(o_out);
            if (start && !busy) board.note_pass(i_in);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_pass(input bit ok, input logic [C2_W-1:0] c2,
                             input logic [HASH_W-1:0] hash);
        t_pass_in p;
        p.read_ok        = ok;
        p.c2_error_count = c2;
        p.sector_hash    = hash;
        start <= 1'b1;
        i_in  <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_requests();
        start <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            while (busy) @(posedge i_clk);
        end
        repeat ($urandom_range(1, 14)) @(posedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending_verdicts.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [CFG_W-1:0] mp, input logic [CFG_W-1:0] rm,
                               input logic [CFG_W-1:0] mn);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_PASSES;
        i_cfg_data <= mp;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REQUIRED_MATCHES;
        i_cfg_data <= rm;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_PASSES;
        i_cfg_data <= mn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_limits(mp, rm, mn);
    endtask

    // Reads mostly repeat a few candidate hashes so that sectors reach real verdicts;
    // bad patches of failed and polluted reads drive the streak endings.
    task automatic random_passes(input int count, input int idle_pct);
        logic [HASH_W-1:0] pool [4];
        logic [HASH_W-1:0] h;
        logic [C2_W-1:0]   c2;
        int                pool_size, refresh, bad_run, roll;
        bit                ok;
        pool_size = 1;
        refresh   = 0;
        bad_run   = 0;
        for (int n = 0; n < count; n++) begin
            if (refresh == 0) begin
                pool_size = $urandom_range(1, 4);
                foreach (pool[k]) begin
                    roll = $urandom_range(0, 15);
                    if (roll == 0) pool[k] = 32'h0000_0000;
                    else if (roll == 1) pool[k] = 32'hFFFF_FFFF;
                    else pool[k] = $urandom();
                end
                refresh = $urandom_range(3, 24);
            end
            refresh--;
            if (bad_run == 0 && $urandom_range(0, 99) < 4) bad_run = $urandom_range(2, 6);
            if (bad_run > 0) begin
                bad_run--;
                ok = 1'($urandom_range(0, 1));
                c2 = C2_W'($urandom_range(1, 4095));
            end else begin
                ok = ($urandom_range(0, 99) >= 10);
                c2 = ($urandom_range(0, 99) < 18) ? C2_W'($urandom_range(1, 4095)) : '0;
            end
            if ($urandom_range(0, 99) < 82) h = pool[$urandom_range(0, pool_size - 1)];
            else h = $urandom();
            send_pass(ok, c2, h);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) pause_requests();
        end
    endtask

    initial begin
        int idle_pct;
        start      <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_MAX_PASSES;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limits: early match on the all-ones hash, then a triple failure.
        send_pass(1'b1, 12'd0, 32'hFFFF_FFFF);
        send_pass(1'b1, 12'd0, 32'h0000_0000);
        send_pass(1'b1, 12'd0, 32'hFFFF_FFFF);
        send_pass(1'b0, 12'hFFF, 32'h5A5A_A5A5);
        send_pass(1'b0, 12'd0, 32'h0000_0000);
        send_pass(1'b0, 12'd0, 32'hFFFF_FFFF);
        // Five unusable reads in a row: failures around polluted early reads.
        send_pass(1'b0, 12'd0, 32'h1111_1111);
        send_pass(1'b1, 12'd1, 32'h2222_2222);
        send_pass(1'b1, 12'hFFF, 32'h3333_3333);
        send_pass(1'b1, 12'h800, 32'h4444_4444);
        send_pass(1'b0, 12'd0, 32'h5555_5555);
        // All distinct hashes: the fallback tie goes to the smallest one.
        for (int k = 0; k < 8; k++) send_pass(1'b1, 12'd0, 32'h1234_5678 ^ (k * 32'h1111_1111));
        settle();

        // Pass limit of zero acts as one; zero match requirement accepts at once.
        load_limits(5'd0, 5'd0, 5'd0);
        send_pass(1'b1, 12'd5, 32'hCAFE_0001);
        send_pass(1'b0, 12'd0, 32'hCAFE_0002);
        settle();

        // Limit above the cap, then lowered below the passes already made.
        load_limits(5'd31, 5'd16, 5'd31);
        repeat (3) send_pass(1'b1, 12'd0, 32'h0BAD_F00D);
        settle();
        load_limits(5'd2, 5'd16, 5'd31);
        send_pass(1'b1, 12'd0, 32'h0BAD_F00D);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 6) begin
                load_limits(CFG_W'(preset_max[ph]), CFG_W'(preset_req[ph]),
                            CFG_W'(preset_min[ph]));
            end else begin
                load_limits(CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(2, 16)),
                            CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(1, 5)),
                            CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(0, 8)));
            end
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 50;
            endcase
            // The closing phases run with no idling at all.
            if (ph >= PHASES - 2) idle_pct = 0;
            random_passes(PHASE_ITEMS, idle_pct);
            settle();
        end

        repeat (80) @(posedge i_clk);
        board.check_drained();
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
